FILE: hdl/ptwal_pkg.sv
// ----------------------------------------------------------------------------
// ptwal_pkg
// Shared widths, default sizes and register indexes of the per-type window
// admission limiter.
// ----------------------------------------------------------------------------
package ptwal_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NUM_TYPES_DEF = 256;
  localparam int MAX_KEEP_DEF  = 8;
  localparam int DAY_BITS_DEF  = 32;

  // Field widths of the stream words and registers.
  localparam int ITEM_TYPE_W     = 8;
  localparam int WINDOW_LEN_W    = 16;
  localparam int MAX_KEPT_W      = 4;
  localparam int DISCARD_TOTAL_W = 32;
  localparam int DAY_INDEX_W     = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 1 + DISCARD_TOTAL_W + DAY_INDEX_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KEPT   = 1'b1;

endpackage

FILE: hdl/per_type_window_admission_limiter.sv
// Words pass through s1, where the tables are read, and the output register.
// Throughput: one word per cycle unless the output stalls or a table clear
// runs; each word does one read-modify-write of the per-type tables, and a
// forwarding register covers same-type neighbors. Reset: synchronous; then
// the fill table is cleared with in_tready low; config writes still go in.
// ----------------------------------------------------------------------------
// per_type_window_admission_limiter
// Admits an arrival unless its type has max_kept (clamped to 1..MAX_KEEP)
// admissions under window_len days old; each arrival takes the next day index.
// ----------------------------------------------------------------------------
module per_type_window_admission_limiter #(
  parameter int NUM_TYPES = ptwal_pkg::NUM_TYPES_DEF,
  parameter int MAX_KEEP  = ptwal_pkg::MAX_KEEP_DEF,
  parameter int DAY_BITS  = ptwal_pkg::DAY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: item_type [7:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ptwal_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tdata: discarded [0], discard_total [32:1], day_index [64:33], zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ptwal_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [ptwal_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptwal_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ptwal_pkg::*;

  localparam int TW     = $clog2(NUM_TYPES);
  localparam int FILL_W = $clog2(MAX_KEEP + 1);
  localparam int SLOT_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int META_W = FILL_W + SLOT_W;
  localparam int ROW_W  = MAX_KEEP * DAY_BITS;
  localparam int KW     = (FILL_W > MAX_KEPT_W) ? FILL_W : MAX_KEPT_W;
  localparam int TYPE_CODES = 2 ** ITEM_TYPE_W;

  typedef logic [MAX_KEEP-1:0][DAY_BITS-1:0] row_t;

  // Configuration.
  logic [WINDOW_LEN_W-1:0] window_len_r;
  logic [MAX_KEPT_W-1:0]   max_kept_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_W'(1);
      max_kept_r   <= MAX_KEPT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: window_len_r <= cfg_data;
        REG_MAX_KEPT:   max_kept_r   <= cfg_data[MAX_KEPT_W-1:0];
      endcase
    end
  end

  // Type reduction to the table size.
  logic [TW-1:0] in_type;

  if (NUM_TYPES >= TYPE_CODES) begin : g_type_wide
    assign in_type = TW'(in_tdata[ITEM_TYPE_W-1:0]);
  end else begin : g_type_fold
    function automatic logic [TYPE_CODES*TW-1:0] build_fold();
      logic [TYPE_CODES*TW-1:0] tbl;
      tbl = '0;
      for (int i = 0; i < TYPE_CODES; i++) begin
        tbl[i*TW +: TW] = TW'(i % NUM_TYPES);
      end
      return tbl;
    endfunction
    localparam logic [TYPE_CODES*TW-1:0] FOLD_TBL = build_fold();
    assign in_type = FOLD_TBL[in_tdata[ITEM_TYPE_W-1:0]*TW +: TW];
  end

  // Pipeline control.
  logic                s1_valid_r;
  logic [TW-1:0]       s1_type_r;
  logic [DAY_BITS-1:0] s1_day_r;
  logic [DAY_BITS-1:0] day_r;
  logic                out_valid_r;
  logic                busy;
  logic                s1_go;
  logic                in_acc;

  assign s1_go     = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~busy & (~s1_valid_r | s1_go);
  assign in_acc    = in_tvalid & in_tready;

  // Table memories.
  logic [META_W-1:0] meta_rd;
  logic [META_W-1:0] meta_new;
  logic [ROW_W-1:0]  row_rd;
  row_t              row_new;

  ptwal_meta_mem #(
    .NUM_TYPES (NUM_TYPES),
    .META_W    (META_W)
  ) u_meta_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (in_type),
    .rd_data (meta_rd),
    .wr_en   (s1_go),
    .wr_addr (s1_type_r),
    .wr_data (meta_new),
    .busy    (busy)
  );

  ptwal_ring_mem #(
    .DEPTH (NUM_TYPES),
    .WIDTH (ROW_W)
  ) u_ring_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_type),
    .rd_data (row_rd),
    .wr_en   (s1_go),
    .wr_addr (s1_type_r),
    .wr_data (row_new)
  );

  // The read for a word issues at the same edge as the previous word's
  // write-back, so the last written entry is forwarded on a type match.
  logic              fw_valid_r;
  logic [TW-1:0]     fw_type_r;
  logic [META_W-1:0] fw_meta_r;
  row_t              fw_row_r;

  logic [META_W-1:0]   meta_cur;
  row_t                row_cur;
  logic [FILL_W-1:0]   fill;
  logic [SLOT_W-1:0]   slot_raw;
  logic [SLOT_W-1:0]   slot;
  logic [FILL_W-1:0]   slot_inc;
  logic [SLOT_W-1:0]   slot_next;
  logic [KW-1:0]       mk_w;
  logic [KW-1:0]       lim_w;
  logic [FILL_W-1:0]   lim;
  logic                full;
  logic [DAY_BITS-1:0] age;
  logic                drop;
  logic [DISCARD_TOTAL_W-1:0] count_r;
  logic [DISCARD_TOTAL_W-1:0] count_nxt;

  always_comb begin
    if (fw_valid_r && (fw_type_r == s1_type_r)) begin
      meta_cur = fw_meta_r;
      row_cur  = fw_row_r;
    end else begin
      meta_cur = meta_rd;
      row_cur  = row_t'(row_rd);
    end

    mk_w = KW'(max_kept_r);
    priority if (mk_w == '0) begin
      lim_w = KW'(1);
    end else if (mk_w > KW'(MAX_KEEP)) begin
      lim_w = KW'(MAX_KEEP);
    end else begin
      lim_w = mk_w;
    end
    lim = FILL_W'(lim_w);

    fill     = meta_cur[FILL_W-1:0];
    slot_raw = meta_cur[META_W-1:FILL_W];
    slot     = (FILL_W'(slot_raw) >= lim) ? '0 : slot_raw;
    full     = (fill >= lim);

    age  = s1_day_r - row_cur[slot];
    drop = full && (age < DAY_BITS'(window_len_r));

    slot_inc  = FILL_W'(slot) + FILL_W'(1);
    slot_next = (slot_inc >= lim) ? '0 : SLOT_W'(slot_inc);

    row_new  = row_cur;
    meta_new = meta_cur;
    if (!drop) begin
      row_new[slot] = s1_day_r;
      meta_new      = {slot_next, full ? fill : fill + FILL_W'(1)};
    end

    count_nxt = count_r;
    if (drop && (count_r != '1)) begin
      count_nxt = count_r + DISCARD_TOTAL_W'(1);
    end
  end

  // Output register.
  logic                       out_discarded_r;
  logic [DISCARD_TOTAL_W-1:0] out_total_r;
  logic [DAY_INDEX_W-1:0]     out_day_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fw_valid_r  <= 1'b0;
      day_r       <= '0;
      count_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        day_r      <= day_r + DAY_BITS'(1);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_go) begin
        out_valid_r <= 1'b1;
        fw_valid_r  <= 1'b1;
        count_r     <= count_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_type_r <= in_type;
      s1_day_r  <= day_r;
    end
    if (s1_go) begin
      fw_type_r       <= s1_type_r;
      fw_meta_r       <= meta_new;
      fw_row_r        <= row_new;
      out_discarded_r <= drop;
      out_total_r     <= count_nxt;
      out_day_r       <= DAY_INDEX_W'(s1_day_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_day_r, out_total_r, out_discarded_r});

endmodule

FILE: hdl/ptwal_meta_mem.sv
// ----------------------------------------------------------------------------
// ptwal_meta_mem
// Per-type fill count and ring write slot. One write and one registered read
// per cycle; a sweep after reset writes every entry to zero.
// ----------------------------------------------------------------------------
module ptwal_meta_mem #(
  parameter int NUM_TYPES = 256,
  parameter int META_W    = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(NUM_TYPES)-1:0] rd_addr,
  output logic [META_W-1:0]            rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(NUM_TYPES)-1:0] wr_addr,
  input  logic [META_W-1:0]            wr_data,
  output logic                         busy
);

  localparam int TW = $clog2(NUM_TYPES);

  logic [META_W-1:0] mem [NUM_TYPES];
  logic [META_W-1:0] rd_data_r;
  logic              clr_active_r;
  logic [TW-1:0]     clr_addr_r;
  logic              mem_we;
  logic [TW-1:0]     mem_waddr;
  logic [META_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == TW'(NUM_TYPES - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign mem_we    = clr_active_r | wr_en;
  assign mem_waddr = clr_active_r ? clr_addr_r : wr_addr;
  assign mem_wdata = clr_active_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

FILE: hdl/ptwal_ring_mem.sv
// ----------------------------------------------------------------------------
// ptwal_ring_mem
// Admitted day indices, one row of ring slots per type. Single write port,
// single registered read port, no reset.
// ----------------------------------------------------------------------------
module ptwal_ring_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 256
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
